[hw/rtl/otseq_pkg.sv]
package otseq_pkg;

	// Width of the per-stage tick counter.
	localparam int TICK_COUNT_WIDTH = 16;
	localparam int LIMIT_WIDTH      = 16;
	localparam int WARM_WIDTH       = 8;
	localparam int CMP_WIDTH        = (TICK_COUNT_WIDTH > LIMIT_WIDTH) ?
	                                  TICK_COUNT_WIDTH : LIMIT_WIDTH;

	localparam int CFG_ADDR_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 16;

	typedef logic [TICK_COUNT_WIDTH-1:0] tick_t;
	typedef logic [LIMIT_WIDTH-1:0]      limit_t;
	typedef logic [WARM_WIDTH-1:0]       warm_t;
	typedef logic [2:0]                  stage_t;
	typedef logic [3:0]                  fail_t;

	// Stage codes.
	localparam stage_t ST_READY     = 3'd0;
	localparam stage_t ST_PREFLIGHT = 3'd1;
	localparam stage_t ST_ARM       = 3'd2;
	localparam stage_t ST_PRESTREAM = 3'd3;
	localparam stage_t ST_OFFB_WAIT = 3'd4;
	localparam stage_t ST_RUN       = 3'd5;
	localparam stage_t ST_DONE      = 3'd6;

	// Failure reasons.
	localparam fail_t FAIL_NONE           = 4'd0;
	localparam fail_t FAIL_NO_STATUS      = 4'd1;
	localparam fail_t FAIL_POS_LOST       = 4'd2;
	localparam fail_t FAIL_NO_POS         = 4'd3;
	localparam fail_t FAIL_PREFLIGHT      = 4'd4;
	localparam fail_t FAIL_NO_ARM         = 4'd5;
	localparam fail_t FAIL_DISARM_PRE     = 4'd6;
	localparam fail_t FAIL_DISARM_OFFB    = 4'd7;
	localparam fail_t FAIL_OFFB_TIMEOUT   = 4'd8;
	localparam fail_t FAIL_DISARM_RUN     = 4'd9;
	localparam fail_t FAIL_LEFT_OFFBOARD  = 4'd10;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_READY_TO     = 3'd0;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_PREFLIGHT_TO = 3'd1;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_ARM_TO       = 3'd2;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_OFFB_TO      = 3'd3;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_WARMUP       = 3'd4;

	localparam limit_t RST_READY_TO     = 16'd400;
	localparam limit_t RST_PREFLIGHT_TO = 16'd200;
	localparam limit_t RST_ARM_TO       = 16'd100;
	localparam limit_t RST_OFFB_TO      = 16'd100;
	localparam warm_t  RST_WARMUP       = 8'd30;

	typedef struct packed {
		limit_t ready_to;
		limit_t preflight_to;
		limit_t arm_to;
		limit_t offb_to;
		warm_t  warmup;
	} cfg_t;

	typedef struct packed {
		logic in_offboard;
		logic preflight_pass;
		logic armed;
		logic position_valid;
		logic status_seen;
	} flags_t;

	typedef struct packed {
		stage_t phase;
		tick_t  ticks;
		warm_t  warm;
	} seq_state_t;

	typedef struct packed {
		fail_t  fail_code;
		logic   failed;
		logic   send_stream;
		logic   send_mode_request;
		logic   send_arm;
		stage_t stage;
	} result_t;

endpackage

[hw/rtl/otseq_cfg.sv]
module otseq_cfg
	import otseq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_ADDR_WIDTH-1:0] wr_addr,
	input  logic [CFG_DATA_WIDTH-1:0] wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Writes to indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_to     <= RST_READY_TO;
			cfg_q.preflight_to <= RST_PREFLIGHT_TO;
			cfg_q.arm_to       <= RST_ARM_TO;
			cfg_q.offb_to      <= RST_OFFB_TO;
			cfg_q.warmup       <= RST_WARMUP;
		end else if (wr_en) begin
			case (wr_addr)
				REG_READY_TO:     cfg_q.ready_to     <= wr_data;
				REG_PREFLIGHT_TO: cfg_q.preflight_to <= wr_data;
				REG_ARM_TO:       cfg_q.arm_to       <= wr_data;
				REG_OFFB_TO:      cfg_q.offb_to      <= wr_data;
				REG_WARMUP:       cfg_q.warmup       <= wr_data[WARM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/otseq_step.sv]
module otseq_step
	import otseq_pkg::*;
(
	input  seq_state_t cur,
	input  flags_t     flags,
	input  cfg_t       cfg,
	output seq_state_t nxt,
	output result_t    res
);

	function automatic logic tick_gt(input tick_t ticks, input limit_t limit);
		logic [CMP_WIDTH-1:0] a;
		logic [CMP_WIDTH-1:0] b;
		a = CMP_WIDTH'(ticks);
		b = CMP_WIDTH'(limit);
		return a > b;
	endfunction

	always_comb begin
		stage_t ph;
		tick_t  t;
		warm_t  w;
		fail_t  code;

		ph   = (cur.phase > ST_DONE) ? ST_DONE : cur.phase;
		nxt  = cur;
		nxt.phase = ph;
		code = FAIL_NONE;
		w    = cur.warm;
		t    = cur.ticks;
		res  = '0;

		if (ph != ST_DONE) begin
			if (t != '1) begin
				t = t + tick_t'(1);
			end
			nxt.ticks = t;

			if (!flags.status_seen) begin
				if (ph == ST_READY && tick_gt(t, cfg.ready_to)) begin
					code = FAIL_NO_STATUS;
				end
			end else if (!flags.position_valid) begin
				if (ph != ST_READY) begin
					code = FAIL_POS_LOST;
				end else if (tick_gt(t, cfg.ready_to)) begin
					code = FAIL_NO_POS;
				end
			end else begin
				case (ph)
					ST_READY, ST_PREFLIGHT: begin
						if (flags.armed) begin
							nxt.warm  = '0;
							nxt.phase = ST_PRESTREAM;
							nxt.ticks = '0;
						end else if (flags.preflight_pass) begin
							res.send_arm = 1'b1;
							nxt.phase    = ST_ARM;
							nxt.ticks    = '0;
						end else if (ph == ST_READY) begin
							nxt.phase = ST_PREFLIGHT;
							nxt.ticks = '0;
						end else if (tick_gt(t, cfg.preflight_to)) begin
							code = FAIL_PREFLIGHT;
						end
					end
					ST_ARM: begin
						if (flags.armed) begin
							nxt.warm  = '0;
							nxt.phase = ST_PRESTREAM;
							nxt.ticks = '0;
						end else if (tick_gt(t, cfg.arm_to)) begin
							code = FAIL_NO_ARM;
						end
					end
					ST_PRESTREAM: begin
						if (!flags.armed) begin
							code = FAIL_DISARM_PRE;
						end else begin
							res.send_stream = 1'b1;
							if (w != '1) begin
								w = w + warm_t'(1);
							end
							nxt.warm = w;
							if (w >= cfg.warmup) begin
								res.send_mode_request = 1'b1;
								nxt.phase = ST_OFFB_WAIT;
								nxt.ticks = '0;
							end
						end
					end
					ST_OFFB_WAIT: begin
						if (!flags.armed) begin
							code = FAIL_DISARM_OFFB;
						end else begin
							res.send_stream = 1'b1;
							if (flags.in_offboard) begin
								nxt.phase = ST_RUN;
								nxt.ticks = '0;
							end else if (tick_gt(t, cfg.offb_to)) begin
								code = FAIL_OFFB_TIMEOUT;
							end
						end
					end
					default: begin
						if (!flags.armed) begin
							code = FAIL_DISARM_RUN;
						end else if (!flags.in_offboard) begin
							code = FAIL_LEFT_OFFBOARD;
						end else begin
							res.send_stream = 1'b1;
						end
					end
				endcase
			end

			if (code != FAIL_NONE) begin
				nxt.phase = ST_DONE;
				nxt.ticks = '0;
			end
		end

		res.stage     = nxt.phase;
		res.failed    = (code != FAIL_NONE);
		res.fail_code = code;
	end

endmodule

[hw/rtl/offboard_takeover_sequencer_unit.sv]
// Path: each item is held in the input register and then in the result register, which
// offers it on the master side; a master-side stall can hold it in either register.
// Throughput: one item per clock while the master side accepts; a stalled result
// holds the input off once the input register is also full.
// Reset: arst_n clears the sequence to the wait ready stage and loads the default
// timeout and warm-up registers; no pipeline entries survive reset.
module offboard_takeover_sequencer_unit
	import otseq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// status_seen, position_valid, armed, preflight_pass, in_offboard, 3 zero bits
	input  logic [7:0]                s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// stage[2:0], send_arm, send_mode_request, send_stream, failed,
	// fail_code[3:0], 5 zero bits
	output logic [15:0]               m_axis_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	cfg_t       cfg;
	seq_state_t st_q;
	seq_state_t st_nxt;
	result_t    res;
	result_t    res_q;
	flags_t     flags_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       advance;

	assign cfg_ready = 1'b1;

	otseq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid & cfg_ready),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	otseq_step u_step (
		.cur   (st_q),
		.flags (flags_s1),
		.cfg   (cfg),
		.nxt   (st_nxt),
		.res   (res)
	);

	// The staged item moves on whenever the result register is empty or draining.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '{phase: ST_READY, ticks: '0, warm: '0};
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (valid_s1 && advance) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			flags_s1 <= flags_t'(s_axis_tdata[4:0]);
		end
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, res_q};

endmodule

[hw/rtl/otseq_checker.sv]
module otseq_checker
	import otseq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// A declared failure carries a reason and lands in the done stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |->
			m_axis_tdata[2:0] == ST_DONE && m_axis_tdata[10:7] != FAIL_NONE)
		else $error("failure without reason or done stage");

	// Without a failure the reason field stays clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[10:7] == FAIL_NONE)
		else $error("reason set without failure");

	// The mode request goes out with the stream, on entry to offboard wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |->
			m_axis_tdata[5] && m_axis_tdata[2:0] == ST_OFFB_WAIT)
		else $error("mode request outside offboard wait entry");

	// The arm command only accompanies entry to the arm stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == ST_ARM)
		else $error("arm command outside arm stage entry");

endmodule

bind offboard_takeover_sequencer_unit otseq_checker u_otseq_checker (.*);

[sim/offboard_takeover_sequencer_unit_tb.sv]
`timescale 1ns / 1ps

module offboard_takeover_sequencer_unit_tb;
	import otseq_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 350;
	localparam int PHASE_COUNT   = 4;
	localparam int HOLD_CYCLES   = 80;
	localparam int FAIL_WINDOW   = 50;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED_LO = 3'd5;

	typedef struct packed {
		flags_t  flags;
		logic    has_want;
		result_t want;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [7:0]                s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [15:0]               m_axis_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	cfg_t       model_cfg;
	seq_state_t model_st;
	result_t    expected_results[$];
	dir_row_t   dir_tab[$];
	result_t    rx_want;
	result_t    rx_got;
	int         mismatch_cnt;
	int         cycle_cnt = 0;
	int         tx_idle_pct;
	int         rx_stall_pct;
	bit         rx_hold_go;

	offboard_takeover_sequencer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic flags_t mk_fl(input logic status, input logic pos, input logic armed,
	                                 input logic pf, input logic offb);
		flags_t f;
		f.status_seen    = status;
		f.position_valid = pos;
		f.armed          = armed;
		f.preflight_pass = pf;
		f.in_offboard    = offb;
		return f;
	endfunction

	function automatic result_t mk_res(input stage_t stage, input logic arm, input logic mode,
	                                   input logic stream, input fail_t code);
		result_t r;
		r.stage             = stage;
		r.send_arm          = arm;
		r.send_mode_request = mode;
		r.send_stream       = stream;
		r.failed            = (code != FAIL_NONE);
		r.fail_code         = code;
		return r;
	endfunction

	// One control tick of the takeover sequence.
	function automatic result_t sequencer_next(input flags_t f, input cfg_t c,
	                                           inout seq_state_t st);
		result_t r;
		fail_t   code;
		r    = '0;
		code = FAIL_NONE;
		if (st.phase > ST_DONE)
			st.phase = ST_DONE;
		if (st.phase != ST_DONE) begin
			if (st.ticks != {TICK_COUNT_WIDTH{1'b1}})
				st.ticks = st.ticks + 1'b1;
			if (!f.status_seen) begin
				if (st.phase == ST_READY && st.ticks > c.ready_to)
					code = FAIL_NO_STATUS;
			end else if (!f.position_valid) begin
				if (st.phase != ST_READY)
					code = FAIL_POS_LOST;
				else if (st.ticks > c.ready_to)
					code = FAIL_NO_POS;
			end else begin
				case (st.phase)
					ST_READY, ST_PREFLIGHT: begin
						if (f.armed) begin
							st.warm  = '0;
							st.phase = ST_PRESTREAM;
							st.ticks = '0;
						end else if (f.preflight_pass) begin
							r.send_arm = 1'b1;
							st.phase   = ST_ARM;
							st.ticks   = '0;
						end else if (st.phase == ST_READY) begin
							st.phase = ST_PREFLIGHT;
							st.ticks = '0;
						end else if (st.ticks > c.preflight_to) begin
							code = FAIL_PREFLIGHT;
						end
					end
					ST_ARM: begin
						if (f.armed) begin
							st.warm  = '0;
							st.phase = ST_PRESTREAM;
							st.ticks = '0;
						end else if (st.ticks > c.arm_to) begin
							code = FAIL_NO_ARM;
						end
					end
					ST_PRESTREAM: begin
						if (!f.armed) begin
							code = FAIL_DISARM_PRE;
						end else begin
							r.send_stream = 1'b1;
							if (st.warm != {WARM_WIDTH{1'b1}})
								st.warm = st.warm + 1'b1;
							// A warm-up setting of zero behaves like one.
							if (st.warm >= c.warmup) begin
								r.send_mode_request = 1'b1;
								st.phase            = ST_OFFB_WAIT;
								st.ticks            = '0;
							end
						end
					end
					ST_OFFB_WAIT: begin
						if (!f.armed) begin
							code = FAIL_DISARM_OFFB;
						end else begin
							r.send_stream = 1'b1;
							if (f.in_offboard) begin
								st.phase = ST_RUN;
								st.ticks = '0;
							end else if (st.ticks > c.offb_to) begin
								code = FAIL_OFFB_TIMEOUT;
							end
						end
					end
					default: begin
						if (!f.armed)
							code = FAIL_DISARM_RUN;
						else if (!f.in_offboard)
							code = FAIL_LEFT_OFFBOARD;
						else
							r.send_stream = 1'b1;
					end
				endcase
			end
			if (code != FAIL_NONE) begin
				st.phase = ST_DONE;
				st.ticks = '0;
			end
		end
		r.stage     = st.phase;
		r.failed    = (code != FAIL_NONE);
		r.fail_code = code;
		return r;
	endfunction

	// Flag mix per stage: advancing is rare so that each stage is held for a while.
	function automatic flags_t draw_flags(input stage_t ph, input bit noisy);
		flags_t f;
		int     arm_pct;
		int     pf_pct;
		int     offb_pct;
		arm_pct  = 50;
		pf_pct   = 50;
		offb_pct = 50;
		case (ph)
			ST_READY: begin
				arm_pct = 5;
				pf_pct  = 10;
			end
			ST_PREFLIGHT: begin
				arm_pct = 1;
				pf_pct  = 2;
			end
			ST_ARM: begin
				arm_pct = 3;
			end
			ST_PRESTREAM: begin
				arm_pct = noisy ? 70 : 95;
			end
			ST_OFFB_WAIT: begin
				arm_pct  = noisy ? 70 : 95;
				offb_pct = 2;
			end
			ST_RUN: begin
				arm_pct  = noisy ? 70 : 95;
				offb_pct = noisy ? 70 : 95;
			end
			default: ;
		endcase
		f.status_seen    = chance(noisy ? 70 : 85);
		f.position_valid = chance(noisy ? 70 : 90);
		f.armed          = chance(arm_pct);
		f.preflight_pass = chance(pf_pct);
		f.in_offboard    = chance(offb_pct);
		return f;
	endfunction

	// Until the closing window, any tick that would end the sequence is redrawn.
	task automatic pick_item(input bit fail_ok, output flags_t f);
		seq_state_t trial;
		result_t    r;
		int         tries;
		bit         found;
		found = 1'b0;
		tries = 0;
		while (!found && tries < 20) begin
			f     = draw_flags(model_st.phase, fail_ok);
			trial = model_st;
			r     = sequencer_next(f, model_cfg, trial);
			found = fail_ok || !r.failed;
			tries++;
		end
		if (!found) begin
			if (model_st.phase == ST_READY)
				f = mk_fl(1'b1, 1'b1, 1'b0, 1'b0, chance(50));
			else
				f = mk_fl(1'b0, chance(50), chance(50), chance(50), chance(50));
		end
	endtask

	task automatic send_item(input flags_t f, input logic has_want, input result_t want);
		result_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, f};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = sequencer_next(f, model_cfg, model_st);
		expected_results.push_back(has_want ? want : r);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= value[CFG_DATA_WIDTH-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (addr)
			REG_READY_TO:     model_cfg.ready_to     = value[LIMIT_WIDTH-1:0];
			REG_PREFLIGHT_TO: model_cfg.preflight_to = value[LIMIT_WIDTH-1:0];
			REG_ARM_TO:       model_cfg.arm_to       = value[LIMIT_WIDTH-1:0];
			REG_OFFB_TO:      model_cfg.offb_to      = value[LIMIT_WIDTH-1:0];
			REG_WARMUP:       model_cfg.warmup       = value[WARM_WIDTH-1:0];
			default: ;
		endcase
	endtask

	function automatic int unsigned pick_limit(input int sel);
		case (sel)
			0:       return $urandom_range(20, 300);
			1:       return 16'hFFFF;
			2:       return 0;
			default: return chance(25) ? 0 : $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	function automatic int unsigned pick_warmup(input int sel);
		int unsigned w;
		case (sel)
			0:       w = $urandom_range(1, 40);
			1:       w = 255;
			2:       w = 0;
			default: w = $urandom_range(1, 255);
		endcase
		// Upper byte is junk that the register must drop.
		return ($urandom_range(0, 255) << 8) | w;
	endfunction

	task automatic configure(input int sel);
		write_reg(REG_READY_TO, pick_limit(sel));
		write_reg(REG_PREFLIGHT_TO, pick_limit(sel));
		write_reg(REG_ARM_TO, pick_limit(sel));
		write_reg(REG_OFFB_TO, pick_limit(sel));
		write_reg(REG_WARMUP, pick_warmup(sel));
		write_reg(REG_UNUSED_LO + CFG_ADDR_WIDTH'($urandom_range(0, 2)),
		          $urandom_range(0, 16'hFFFF));
		cfg_valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off that it counts itself.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left     = 0;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (rx_hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !chance(rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rx_got = result_t'(m_axis_tdata[10:0]);
			if (expected_results.size() == 0) begin
				$display("%0t: transfer with no expected result, expected none actual %h",
				         $time, m_axis_tdata);
				mismatch_cnt++;
			end else begin
				rx_want = expected_results.pop_front();
				check_field("stage", 32'(rx_want.stage), 32'(rx_got.stage));
				check_field("send_arm", 32'(rx_want.send_arm), 32'(rx_got.send_arm));
				check_field("send_mode_request", 32'(rx_want.send_mode_request),
				            32'(rx_got.send_mode_request));
				check_field("send_stream", 32'(rx_want.send_stream),
				            32'(rx_got.send_stream));
				check_field("failed", 32'(rx_want.failed), 32'(rx_got.failed));
				check_field("fail_code", 32'(rx_want.fail_code), 32'(rx_got.fail_code));
			end
			check_field("pad bits", 0, 32'(m_axis_tdata[15:11]));
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		flags_t f;
		int     ph;
		int     n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		mismatch_cnt  = 0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		rx_hold_go    = 1'b0;
		model_cfg = {RST_READY_TO, RST_PREFLIGHT_TO, RST_ARM_TO, RST_OFFB_TO, RST_WARMUP};
		model_st       = '0;
		model_st.phase = ST_READY;

		// Early ticks under the reset timeouts: missing status or position must not
		// fail yet, and status with position moves on to the preflight wait.
		dir_tab.push_back({mk_fl(0, 0, 0, 0, 0), 1'b1, mk_res(ST_READY, 0, 0, 0, FAIL_NONE)});
		dir_tab.push_back({mk_fl(1, 0, 1, 1, 1), 1'b1, mk_res(ST_READY, 0, 0, 0, FAIL_NONE)});
		dir_tab.push_back({mk_fl(0, 1, 1, 1, 1), 1'b1, mk_res(ST_READY, 0, 0, 0, FAIL_NONE)});
		dir_tab.push_back({mk_fl(1, 1, 0, 0, 1), 1'b1,
		                   mk_res(ST_PREFLIGHT, 0, 0, 0, FAIL_NONE)});
		dir_tab.push_back({mk_fl(0, 1, 1, 1, 1), 1'b1,
		                   mk_res(ST_PREFLIGHT, 0, 0, 0, FAIL_NONE)});
		dir_tab.push_back({mk_fl(1, 1, 0, 0, 0), 1'b1,
		                   mk_res(ST_PREFLIGHT, 0, 0, 0, FAIL_NONE)});
		dir_tab.push_back({mk_fl(0, 0, 0, 0, 0), 1'b0, result_t'('0)});
		dir_tab.push_back({mk_fl(1, 1, 0, 0, 1), 1'b0, result_t'('0)});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < dir_tab.size(); n++)
			send_item(dir_tab[n].flags, dir_tab[n].has_want, dir_tab[n].want);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_results();
			configure(ph);
			case (ph)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct  = 88;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 88;
				end
				default: begin
					tx_idle_pct  = 28;
					rx_stall_pct = 28;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 100)
					rx_hold_go = 1'b1;
				// The sequence is allowed to fail only near the end, since done latches.
				pick_item(ph == PHASE_COUNT - 1 && n >= PHASE_ITEMS - FAIL_WINDOW, f);
				while (chance(tx_idle_pct)) begin
					s_axis_tvalid <= 1'b0;
					@(posedge clk);
				end
				send_item(f, 1'b0, result_t'('0));
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
